[hw/rtl/cmvg_pkg.sv]
package cmvg_pkg;

  localparam int MaxSegments = 1024;
  localparam int IdxW        = $clog2(MaxSegments);
  localparam int SegW        = IdxW + 1;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 64;
  localparam int ColorW      = 24;
  localparam int RowW        = 64;
  localparam int EntW        = 16;
  localparam int NumRows     = 4;
  localparam int PtW         = 18;
  localparam int CoordW      = 32;

  localparam int NumVtx = 6;
  localparam int VtxW   = 3;
  localparam logic [VtxW-1:0] LastVtx = VtxW'(NumVtx - 1);

  localparam logic [SegW-1:0] SegReset   = SegW'(16);
  localparam logic [ColorW-1:0] ColorReset = 24'hFF_FFFF;
  localparam logic [RowW-1:0] Row0Reset = 64'h0800_0000_0000_0000;
  localparam logic [RowW-1:0] Row1Reset = 64'h0000_0800_0000_0000;
  localparam logic [RowW-1:0] Row2Reset = 64'h0000_0000_0800_0000;
  localparam logic [RowW-1:0] Row3Reset = 64'h0000_0000_0000_0800;

  localparam logic signed [PtW-1:0] OneQ16 = 18'sd65536;
  localparam logic [CoordW-1:0] PosSat = 32'h7FFF_FFFF;
  localparam logic [CoordW-1:0] NegSat = 32'h8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    RegCapped, RegSegCount, RegColor, RegRow0, RegRow1, RegRow2, RegRow3
  } cfg_reg_e;

  typedef enum logic [1:0] {PtA, PtB, PtCentre} pt_sel_e;

  typedef struct packed {
    logic    x_one;
    pt_sel_e pt;
  } vtx_sel_t;

  typedef struct packed {
    logic            kind;
    logic [IdxW-1:0] segment_index;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic [ColorW-1:0]        color;
    logic                     w_zero;
    logic                     last;
  } out_vtx_t;

  // pair of rim points for one segment
  typedef struct packed {
    logic                  kind;
    logic signed [PtW-1:0] ay;
    logic signed [PtW-1:0] az;
    logic signed [PtW-1:0] by;
    logic signed [PtW-1:0] bz;
  } rim_t;

  typedef struct packed {
    logic signed [PtW-1:0] vx;
    logic signed [PtW-1:0] vy;
    logic signed [PtW-1:0] vz;
    logic                  last;
  } xf_in_t;

  // side: A0 B0 A1 B0 B1 A1, cap: A0 B0 C0 B1 A1 C1
  function automatic vtx_sel_t vtx_pick(logic kind, logic [VtxW-1:0] n);
    vtx_sel_t r;
    r.x_one = 1'b0;
    r.pt    = PtA;
    case (n)
      3'd0: begin r.x_one = 1'b0; r.pt = PtA; end
      3'd1: begin r.x_one = 1'b0; r.pt = PtB; end
      3'd2: begin r.x_one = !kind; r.pt = kind ? PtCentre : PtA; end
      3'd3: begin r.x_one = kind; r.pt = PtB; end
      3'd4: begin r.x_one = 1'b1; r.pt = kind ? PtA : PtB; end
      3'd5: begin r.x_one = 1'b1; r.pt = kind ? PtCentre : PtA; end
      default: begin r.x_one = 1'b0; r.pt = PtA; end
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/cmvg_rim.sv]
module cmvg_rim (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  cmvg_pkg::in_item_t       item_i,
  input  logic [cmvg_pkg::SegW-1:0] seg_n_i,
  output logic                     valid_o,
  output cmvg_pkg::rim_t           rim_o
);
  import cmvg_pkg::*;

  localparam int PhW         = 32;
  localparam int DivPerStage = 4;
  localparam int DivBits     = ((SegW + PhW + DivPerStage - 1) / DivPerStage) * DivPerStage;
  localparam int DivStages   = DivBits / DivPerStage;
  localparam int CordicSteps = 30;
  localparam int CorW        = 34;
  localparam int RoundShift  = 14;
  localparam logic signed [CorW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [CorW-1:0] RoundBias  = 34'sd8192;

  typedef struct packed {
    logic [SegW-1:0]    rem;
    logic [DivBits-1:0] qd;
  } ldiv_t;

  typedef struct packed {
    logic  kind;
    ldiv_t a;
    ldiv_t b;
  } div_stg_t;

  typedef struct packed {
    logic signed [CorW-1:0] x;
    logic signed [CorW-1:0] y;
    logic signed [CorW-1:0] z;
    logic [1:0]             quad;
  } cor_t;

  typedef struct packed {
    logic kind;
    cor_t a;
    cor_t b;
  } cor_stg_t;

  typedef struct packed {
    logic signed [PtW-1:0] c;
    logic signed [PtW-1:0] s;
  } pt_t;

  // arctangent of 2^-k in 2^-32 turns
  function automatic logic signed [CorW-1:0] atan_turn(int k);
    logic signed [CorW-1:0] r;
    case (k)
      0:  r = 34'sd536870912;
      1:  r = 34'sd316933406;
      2:  r = 34'sd167458907;
      3:  r = 34'sd85004756;
      4:  r = 34'sd42667331;
      5:  r = 34'sd21354465;
      6:  r = 34'sd10679838;
      7:  r = 34'sd5340245;
      8:  r = 34'sd2670163;
      9:  r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      19: r = 34'sd1304;
      20: r = 34'sd652;
      21: r = 34'sd326;
      22: r = 34'sd163;
      23: r = 34'sd81;
      24: r = 34'sd41;
      25: r = 34'sd20;
      26: r = 34'sd10;
      27: r = 34'sd5;
      28: r = 34'sd3;
      29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // restoring long division, a few quotient bits per stage
  function automatic ldiv_t ldiv_step(ldiv_t s, logic [SegW-1:0] n);
    ldiv_t         r;
    logic [SegW:0] sh;
    r = s;
    for (int b = 0; b < DivPerStage; b++) begin
      sh = {r.rem, r.qd[DivBits-1]};
      if (sh >= {1'b0, n}) begin
        r.rem = SegW'(sh - {1'b0, n});
        r.qd  = {r.qd[DivBits-2:0], 1'b1};
      end else begin
        r.rem = sh[SegW-1:0];
        r.qd  = {r.qd[DivBits-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic cor_t cordic_init(logic [PhW-1:0] ph);
    cor_t r;
    r.x    = CordicGain;
    r.y    = '0;
    r.z    = $signed(CorW'(ph[PhW-3:0]));
    r.quad = ph[PhW-1:PhW-2];
    return r;
  endfunction

  function automatic cor_t cordic_step(cor_t c, int k);
    cor_t                   r;
    logic signed [CorW-1:0] dx;
    logic signed [CorW-1:0] dy;
    logic signed [CorW-1:0] at;
    r  = c;
    dx = c.y >>> k;
    dy = c.x >>> k;
    at = atan_turn(k);
    if (!c.z[CorW-1]) begin
      r.x = c.x - dx;
      r.y = c.y + dy;
      r.z = c.z - at;
    end else begin
      r.x = c.x + dx;
      r.y = c.y - dy;
      r.z = c.z + at;
    end
    return r;
  endfunction

  function automatic logic signed [PtW-1:0] q16_round(logic signed [CorW-1:0] v);
    logic signed [CorW-1:0] t;
    t = v + RoundBias;
    return t[RoundShift+PtW-1:RoundShift];
  endfunction

  // fold the quarter turn back in, then round to Q16.16
  function automatic pt_t cordic_out(cor_t c);
    pt_t                    r;
    logic signed [CorW-1:0] cc;
    logic signed [CorW-1:0] ss;
    case (c.quad)
      2'd0: begin cc = c.x;  ss = c.y;  end
      2'd1: begin cc = -c.y; ss = c.x;  end
      2'd2: begin cc = -c.x; ss = -c.y; end
      default: begin cc = c.y; ss = -c.x; end
    endcase
    r.c = q16_round(cc);
    r.s = q16_round(ss);
    return r;
  endfunction

  div_stg_t                div_d [DivStages];
  div_stg_t                div_q [DivStages];
  logic [DivStages-1:0]    div_v_q;
  cor_stg_t                cor_d [CordicSteps];
  cor_stg_t                cor_q [CordicSteps];
  logic [CordicSteps-1:0]  cor_v_q;
  rim_t                    rim_d;
  rim_t                    rim_q;
  logic                    rim_v_q;
  logic [SegW-1:0]         k0;
  logic [SegW-1:0]         k1;
  ldiv_t                   init_a;
  ldiv_t                   init_b;
  pt_t                     pa;
  pt_t                     pb;

  always_comb begin
    k0         = {1'b0, item_i.segment_index};
    k1         = SegW'(k0 + 1'b1);
    init_a.rem = '0;
    init_a.qd  = DivBits'({k0, {PhW{1'b0}}});
    init_b.rem = '0;
    init_b.qd  = DivBits'({k1, {PhW{1'b0}}});

    div_d[0].kind = item_i.kind;
    div_d[0].a    = ldiv_step(init_a, seg_n_i);
    div_d[0].b    = ldiv_step(init_b, seg_n_i);
    for (int s = 1; s < DivStages; s++) begin
      div_d[s].kind = div_q[s-1].kind;
      div_d[s].a    = ldiv_step(div_q[s-1].a, seg_n_i);
      div_d[s].b    = ldiv_step(div_q[s-1].b, seg_n_i);
    end

    // quotient modulo a full turn is the phase
    cor_d[0].kind = div_q[DivStages-1].kind;
    cor_d[0].a    = cordic_step(cordic_init(div_q[DivStages-1].a.qd[PhW-1:0]), 0);
    cor_d[0].b    = cordic_step(cordic_init(div_q[DivStages-1].b.qd[PhW-1:0]), 0);
    for (int s = 1; s < CordicSteps; s++) begin
      cor_d[s].kind = cor_q[s-1].kind;
      cor_d[s].a    = cordic_step(cor_q[s-1].a, s);
      cor_d[s].b    = cordic_step(cor_q[s-1].b, s);
    end

    pa         = cordic_out(cor_q[CordicSteps-1].a);
    pb         = cordic_out(cor_q[CordicSteps-1].b);
    rim_d.kind = cor_q[CordicSteps-1].kind;
    rim_d.ay   = pa.c;
    rim_d.az   = pa.s;
    rim_d.by   = pb.c;
    rim_d.bz   = pb.s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_v_q <= '0;
      cor_v_q <= '0;
      rim_v_q <= 1'b0;
    end else if (en_i) begin
      div_v_q <= {div_v_q[DivStages-2:0], valid_i};
      cor_v_q <= {cor_v_q[CordicSteps-2:0], div_v_q[DivStages-1]};
      rim_v_q <= cor_v_q[CordicSteps-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < DivStages; s++) div_q[s] <= div_d[s];
      for (int s = 0; s < CordicSteps; s++) cor_q[s] <= cor_d[s];
      rim_q <= rim_d;
    end
  end

  assign valid_o = rim_v_q;
  assign rim_o   = rim_q;

endmodule

[hw/rtl/cmvg_xform.sv]
module cmvg_xform (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          valid_i,
  input  cmvg_pkg::xf_in_t                              vtx_i,
  input  logic [cmvg_pkg::NumRows-1:0][cmvg_pkg::RowW-1:0] mat_i,
  input  logic [cmvg_pkg::ColorW-1:0]                   color_i,
  output logic                                          valid_o,
  output cmvg_pkg::out_vtx_t                            vtx_o
);
  import cmvg_pkg::*;

  localparam int ProdW     = EntW + PtW;
  localparam int TW        = ProdW + 2;
  localparam int FracShift = 16;
  localparam int DW        = TW + FracShift + 1;
  localparam int QW        = CoordW;
  localparam int NumCoord  = 3;

  typedef struct packed {
    logic [NumCoord-1:0][TW-1:0] mag;
    logic [TW-1:0]               den;
    logic [NumCoord-1:0]         neg;
    logic [NumCoord-1:0]         t_pos;
    logic [NumCoord-1:0]         t_neg;
    logic                        wz;
    logic                        last;
  } wa_t;

  typedef struct packed {
    logic [TW-1:0] rem;
    logic [QW-1:0] qd;
    logic          neg;
    logic          ovf;
    logic          t_pos;
    logic          t_neg;
  } wdiv_t;

  typedef struct packed {
    wdiv_t [NumCoord-1:0] c;
    logic [TW-1:0]        den;
    logic                 wz;
    logic                 last;
  } wstg_t;

  function automatic logic signed [EntW-1:0] mat_ent(logic [RowW-1:0] row, int col);
    return row[RowW-1-EntW*col -: EntW];
  endfunction

  function automatic wdiv_t wdiv_step(wdiv_t s, logic [TW-1:0] den);
    wdiv_t       r;
    logic [TW:0] sh;
    r  = s;
    sh = {s.rem, s.qd[QW-1]};
    if (sh >= {1'b0, den}) begin
      r.rem = TW'(sh - {1'b0, den});
      r.qd  = {s.qd[QW-2:0], 1'b1};
    end else begin
      r.rem = sh[TW-1:0];
      r.qd  = {s.qd[QW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [CoordW-1:0] coord_out(wdiv_t d, logic wz);
    if (wz) return d.t_pos ? PosSat : (d.t_neg ? NegSat : '0);
    if (d.neg) return (d.ovf || d.qd > NegSat) ? NegSat : CoordW'(32'd0 - d.qd);
    return (d.ovf || d.qd[QW-1]) ? PosSat : d.qd;
  endfunction

  logic signed [ProdW-1:0] prod_d [NumRows][NumCoord];
  logic signed [ProdW-1:0] prod_q [NumRows][NumCoord];
  logic                    p_last_q;
  logic signed [TW-1:0]    t_d [NumRows];
  logic signed [TW-1:0]    t_q [NumRows];
  logic                    s_last_q;
  wa_t                     a_d;
  wa_t                     a_q;
  wstg_t                   b_d;
  wstg_t                   wd_d [QW];
  wstg_t                   wd_q [QW];
  wstg_t                   b_q;
  out_vtx_t                o_d;
  out_vtx_t                o_q;
  logic                    p_v_q;
  logic                    s_v_q;
  logic                    a_v_q;
  logic                    b_v_q;
  logic [QW-1:0]           wd_v_q;
  logic                    o_v_q;
  logic [DW-1:0]           dvd;
  logic signed [EntW-1:0]  e;
  logic signed [TW-1:0]    tw;

  always_comb begin
    // products of the matrix with (x, y, z)
    for (int r = 0; r < NumRows; r++) begin
      e = mat_ent(mat_i[r], 0);
      prod_d[r][0] = e * vtx_i.vx;
      e = mat_ent(mat_i[r], 1);
      prod_d[r][1] = e * vtx_i.vy;
      e = mat_ent(mat_i[r], 2);
      prod_d[r][2] = e * vtx_i.vz;
    end

    // w column times one in Q16.16 is a shift
    for (int r = 0; r < NumRows; r++) begin
      e = mat_ent(mat_i[r], 3);
      t_d[r] = TW'(prod_q[r][0]) + TW'(prod_q[r][1]) + TW'(prod_q[r][2]) +
               (TW'(e) <<< FracShift);
    end

    tw       = t_q[NumRows-1];
    a_d.den  = tw[TW-1] ? TW'(-tw) : TW'(tw);
    a_d.wz   = (tw == '0);
    a_d.last = s_last_q;
    for (int j = 0; j < NumCoord; j++) begin
      a_d.mag[j]   = t_q[j][TW-1] ? TW'(-t_q[j]) : TW'(t_q[j]);
      a_d.neg[j]   = t_q[j][TW-1] != tw[TW-1];
      a_d.t_neg[j] = t_q[j][TW-1];
      a_d.t_pos[j] = !t_q[j][TW-1] && (t_q[j] != '0);
    end

    // round to nearest: add half the divisor before dividing
    b_d.den  = a_q.den;
    b_d.wz   = a_q.wz;
    b_d.last = a_q.last;
    for (int j = 0; j < NumCoord; j++) begin
      dvd = DW'({a_q.mag[j], {FracShift{1'b0}}}) + DW'(a_q.den >> 1);
      b_d.c[j].ovf   = TW'(dvd[DW-1:QW]) >= a_q.den;
      b_d.c[j].rem   = b_d.c[j].ovf ? '0 : TW'(dvd[DW-1:QW]);
      b_d.c[j].qd    = dvd[QW-1:0];
      b_d.c[j].neg   = a_q.neg[j];
      b_d.c[j].t_pos = a_q.t_pos[j];
      b_d.c[j].t_neg = a_q.t_neg[j];
    end

    for (int s = 0; s < QW; s++) begin
      wd_d[s] = (s == 0) ? b_q : wd_q[(s == 0) ? 0 : s - 1];
      for (int j = 0; j < NumCoord; j++) begin
        wd_d[s].c[j] = wdiv_step(wd_d[s].c[j], wd_d[s].den);
      end
    end

    o_d.pos_x  = $signed(coord_out(wd_q[QW-1].c[0], wd_q[QW-1].wz));
    o_d.pos_y  = $signed(coord_out(wd_q[QW-1].c[1], wd_q[QW-1].wz));
    o_d.pos_z  = $signed(coord_out(wd_q[QW-1].c[2], wd_q[QW-1].wz));
    o_d.color  = color_i;
    o_d.w_zero = wd_q[QW-1].wz;
    o_d.last   = wd_q[QW-1].last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q  <= 1'b0;
      s_v_q  <= 1'b0;
      a_v_q  <= 1'b0;
      b_v_q  <= 1'b0;
      wd_v_q <= '0;
      o_v_q  <= 1'b0;
    end else if (en_i) begin
      p_v_q  <= valid_i;
      s_v_q  <= p_v_q;
      a_v_q  <= s_v_q;
      b_v_q  <= a_v_q;
      wd_v_q <= {wd_v_q[QW-2:0], b_v_q};
      o_v_q  <= wd_v_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= prod_d;
      p_last_q <= vtx_i.last;
      t_q      <= t_d;
      s_last_q <= p_last_q;
      a_q      <= a_d;
      b_q      <= b_d;
      for (int s = 0; s < QW; s++) wd_q[s] <= wd_d[s];
      o_q      <= o_d;
    end
  end

  assign valid_o = o_v_q;
  assign vtx_o   = o_q;

endmodule

[hw/rtl/cylinder_mesh_vertex_generator.sv]
// channel   direction  handshake                  payload
// cfg       in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
// in        in         in_valid_i / in_ready_o    in_data_i (kind, segment_index)
// out       out        out_valid_o / out_ready_i  out_data_o (one vertex)
//
// one item gives six vertices, one per cycle while out is not stalled; a cap
// item with capping off gives nothing.
// on its way out an item passes the phase divider, 30 cordic stages, the
// matrix stages and a 32 stage divide by w.
// reset clears valid bits and loads the register defaults; no clearing pass.
// a stall on out freezes the pipeline; the input register still takes an item while it is empty.
module cylinder_mesh_vertex_generator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cmvg_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [cmvg_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  cmvg_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output cmvg_pkg::out_vtx_t                out_data_o
);
  import cmvg_pkg::*;

  logic                           capped_q;
  logic [SegW-1:0]                seg_q;
  logic [ColorW-1:0]              color_q;
  logic [NumRows-1:0][RowW-1:0]   mat_q;
  logic [SegW-1:0]                seg_n;

  logic       inbuf_v_q;
  in_item_t   inbuf_q;
  logic       en;
  logic       ien;
  logic       rim_v;
  rim_t       rim;
  logic       exp_free;
  logic       take;
  logic       drop;

  logic            busy_q;
  logic [VtxW-1:0] cnt_q;
  rim_t            pts_q;
  vtx_sel_t        sel;
  xf_in_t          xf_in;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capped_q <= 1'b0;
      seg_q    <= SegReset;
      color_q  <= ColorReset;
      mat_q[0] <= Row0Reset;
      mat_q[1] <= Row1Reset;
      mat_q[2] <= Row2Reset;
      mat_q[3] <= Row3Reset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        RegCapped:   capped_q <= cfg_data_i[0];
        RegSegCount: seg_q    <= cfg_data_i[SegW-1:0];
        RegColor:    color_q  <= cfg_data_i[ColorW-1:0];
        RegRow0:     mat_q[0] <= cfg_data_i;
        RegRow1:     mat_q[1] <= cfg_data_i;
        RegRow2:     mat_q[2] <= cfg_data_i;
        RegRow3:     mat_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero count acts as one, large counts clamp
  assign seg_n = (seg_q == '0) ? SegW'(1) :
                 (seg_q > SegW'(MaxSegments)) ? SegW'(MaxSegments) : seg_q;

  assign en       = !out_valid_o || out_ready_i;
  assign exp_free = !busy_q || (cnt_q == LastVtx);
  assign ien      = en && (!rim_v || exp_free);
  assign take     = en && rim_v && exp_free;
  assign drop     = rim.kind && !capped_q;

  assign in_ready_o = !inbuf_v_q || ien;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inbuf_v_q <= 1'b0;
    end else if (in_ready_o) begin
      inbuf_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) inbuf_q <= in_data_i;
  end

  cmvg_rim u_rim (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (ien),
    .valid_i (inbuf_v_q),
    .item_i  (inbuf_q),
    .seg_n_i (seg_n),
    .valid_o (rim_v),
    .rim_o   (rim)
  );

  // vertex sequencer: six vertices per segment
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (en) begin
      if (busy_q) begin
        cnt_q <= VtxW'(cnt_q + 1'b1);
        if (cnt_q == LastVtx) busy_q <= 1'b0;
      end
      if (take && !drop) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && !drop) pts_q <= rim;
  end

  always_comb begin
    sel      = vtx_pick(pts_q.kind, cnt_q);
    xf_in.vx = sel.x_one ? OneQ16 : '0;
    case (sel.pt)
      PtA: begin
        xf_in.vy = pts_q.ay;
        xf_in.vz = pts_q.az;
      end
      PtB: begin
        xf_in.vy = pts_q.by;
        xf_in.vz = pts_q.bz;
      end
      default: begin
        xf_in.vy = '0;
        xf_in.vz = '0;
      end
    endcase
    xf_in.last = (cnt_q == LastVtx);
  end

  cmvg_xform u_xform (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (busy_q),
    .vtx_i   (xf_in),
    .mat_i   (mat_q),
    .color_i (color_q),
    .valid_o (out_valid_o),
    .vtx_o   (out_data_o)
  );

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= LastVtx)
    else $error("vertex counter past last vertex");

  a_inbuf_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inbuf_v_q && !ien |=> inbuf_v_q && $stable(inbuf_q))
    else $error("input register overwritten while pipeline held");

  a_wzero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.w_zero |->
      (out_data_o.pos_x == PosSat || out_data_o.pos_x == NegSat || out_data_o.pos_x == '0))
    else $error("zero w without saturated coordinate");

  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !drop |=> busy_q && cnt_q == '0)
    else $error("segment taken but sequencer not started");

endmodule

[sim/tb_cylinder_mesh_vertex_generator.sv]
`timescale 1ns / 100ps

module tb_cylinder_mesh_vertex_generator;
  import cmvg_pkg::*;

  localparam int IdleLimit = 20000;
  localparam int DrainCycles = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_vtx_t out_data_o;

  cylinder_mesh_vertex_generator uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow copy of the registers
  logic sh_capped;
  logic [SegW-1:0] sh_segs;
  logic [ColorW-1:0] sh_color;
  logic [RowW-1:0] sh_rows[NumRows];

  out_vtx_t vertex_queue[$];
  int errors = 0;
  int n_items = 0;
  int n_vertices = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit offering = 1'b0;
  int stall_mode = 0;
  logic [63:0] arc_step[30];

  initial begin
    arc_step = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1};
  end

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  task automatic rim_cos_sin(input logic [31:0] phase, output longint c,
                             output longint s);
    longint x, y, z, dx, dy, cc, ss;
    logic [1:0] quad;
    x = 652032874;
    y = 0;
    z = longint'(phase[29:0]);
    quad = phase[31:30];
    for (int k = 0; k < 30; k++) begin
      dx = shr_floor(y, k);
      dy = shr_floor(x, k);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(arc_step[k]);
      end else begin
        x += dx; y -= dy; z += longint'(arc_step[k]);
      end
    end
    case (quad)
      2'd0: begin cc = x; ss = y; end
      2'd1: begin cc = -y; ss = x; end
      2'd2: begin cc = -x; ss = -y; end
      default: begin cc = y; ss = -x; end
    endcase
    c = shr_floor(cc + 8192, 14);
    s = shr_floor(ss + 8192, 14);
  endtask

  function automatic longint coef(int r, int col);
    logic [15:0] e;
    e = sh_rows[r][(3 - col) * 16 +: 16];
    return longint'($signed(e));
  endfunction

  function automatic logic [31:0] scaled_div(longint t, longint w);
    bit neg;
    logic [63:0] num, den, q;
    neg = (t < 0) != (w < 0);
    num = 64'(t < 0 ? -t : t) << 16;
    den = 64'(w < 0 ? -w : w);
    q = (num + den / 2) / den;
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return 32'(0) - q[31:0];
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic out_vtx_t transform_vertex(longint vx, longint vy, longint vz,
                                                bit is_last);
    longint t[4];
    logic [31:0] p[3];
    out_vtx_t v;
    for (int r = 0; r < 4; r++)
      t[r] = coef(r, 0) * vx + coef(r, 1) * vy + coef(r, 2) * vz + coef(r, 3) * 65536;
    for (int j = 0; j < 3; j++) begin
      if (t[3] == 0)
        p[j] = t[j] > 0 ? PosSat : (t[j] < 0 ? NegSat : 32'd0);
      else
        p[j] = scaled_div(t[j], t[3]);
    end
    v.pos_x = p[0];
    v.pos_y = p[1];
    v.pos_z = p[2];
    v.color = sh_color;
    v.w_zero = (t[3] == 0);
    v.last = is_last;
    return v;
  endfunction

  task automatic predict_segment(in_item_t it);
    logic [63:0] n, i;
    longint ay, az, by, bz;
    n = 64'(sh_segs);
    if (n == 0) n = 1;
    if (n > MaxSegments) n = MaxSegments;
    if (it.kind && !sh_capped) return;
    i = 64'(it.segment_index);
    rim_cos_sin(32'((i << 32) / n), ay, az);
    rim_cos_sin(32'(((i + 1) << 32) / n), by, bz);
    vertex_queue.push_back(transform_vertex(0, ay, az, 0));
    vertex_queue.push_back(transform_vertex(0, by, bz, 0));
    if (!it.kind) begin
      vertex_queue.push_back(transform_vertex(65536, ay, az, 0));
      vertex_queue.push_back(transform_vertex(0, by, bz, 0));
      vertex_queue.push_back(transform_vertex(65536, by, bz, 0));
      vertex_queue.push_back(transform_vertex(65536, ay, az, 1));
    end else begin
      vertex_queue.push_back(transform_vertex(0, 0, 0, 0));
      vertex_queue.push_back(transform_vertex(65536, by, bz, 0));
      vertex_queue.push_back(transform_vertex(65536, ay, az, 0));
      vertex_queue.push_back(transform_vertex(65536, 0, 0, 1));
    end
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else if (stall_mode == 0) out_ready_i <= 1'b1;
    else if (stall_mode == 1) out_ready_i <= ($urandom_range(0, 3) != 0);
    else out_ready_i <= ($urandom_range(0, 1) != 0);
  end

  // result checker and watchdog
  always @(posedge clk_i) begin
    out_vtx_t exp_v;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o) || hold_off)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        n_vertices++;
        if (vertex_queue.size() == 0) begin
          $error("vertex with none expected");
          errors++;
        end else begin
          exp_v = vertex_queue.pop_front();
          if (out_data_o.pos_x !== exp_v.pos_x) begin
            $error("pos_x exp %h got %h", exp_v.pos_x, out_data_o.pos_x); errors++;
          end
          if (out_data_o.pos_y !== exp_v.pos_y) begin
            $error("pos_y exp %h got %h", exp_v.pos_y, out_data_o.pos_y); errors++;
          end
          if (out_data_o.pos_z !== exp_v.pos_z) begin
            $error("pos_z exp %h got %h", exp_v.pos_z, out_data_o.pos_z); errors++;
          end
          if (out_data_o.color !== exp_v.color) begin
            $error("color exp %h got %h", exp_v.color, out_data_o.color); errors++;
          end
          if (out_data_o.w_zero !== exp_v.w_zero) begin
            $error("w_zero exp %b got %b", exp_v.w_zero, out_data_o.w_zero); errors++;
          end
          if (out_data_o.last !== exp_v.last) begin
            $error("last exp %b got %b", exp_v.last, out_data_o.last); errors++;
          end
        end
      end
    end
  end

  // valid stays up between back to back transactions
  task automatic send_segment(logic kind, logic [IdxW-1:0] idx);
    in_item_t it;
    it.kind = kind;
    it.segment_index = idx;
    if (!offering) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    offering = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_segment(it);
    n_items++;
  endtask

  task automatic stop_input();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic wait_drained();
    stop_input();
    while (vertex_queue.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // registers change only with the pipeline empty
  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    wait_drained();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegCapped: sh_capped = val[0];
      RegSegCount: sh_segs = val[SegW-1:0];
      RegColor: sh_color = val[ColorW-1:0];
      RegRow0: sh_rows[0] = val;
      RegRow1: sh_rows[1] = val;
      RegRow2: sh_rows[2] = val;
      RegRow3: sh_rows[3] = val;
      default: ;
    endcase
  endtask

  function automatic logic [63:0] rand_row();
    return {16'($urandom_range(0, 4095) - 2048), 16'($urandom_range(0, 4095) - 2048),
            16'($urandom_range(0, 4095) - 2048), 16'($urandom_range(0, 4095) - 2048)};
  endfunction

  // random bursts with gaps, sides before caps
  task automatic random_burst(int count, int max_idx);
    int sides;
    sides = $urandom_range(count / 2, count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 5) == 0) begin
        stop_input();
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
      send_segment(k >= sides, IdxW'($urandom_range(0, max_idx)));
    end
    stop_input();
  endtask

  task automatic test_directed_identity();
    stall_mode = 0;
    send_segment(1'b0, '0);
    send_segment(1'b0, 10'd15);
    send_segment(1'b0, 10'd1023);
    send_segment(1'b1, 10'd3);
    write_reg(RegCapped, 64'd1);
    send_segment(1'b0, 10'd4);
    send_segment(1'b1, 10'd0);
    send_segment(1'b1, 10'd16);
    wait_drained();
  endtask

  task automatic test_segment_extremes();
    write_reg(RegSegCount, 64'd0);
    send_segment(1'b0, 10'd0);
    write_reg(RegSegCount, 64'd2047);
    send_segment(1'b0, 10'd1023);
    send_segment(1'b1, 10'd512);
    write_reg(RegSegCount, 64'd1024);
    send_segment(1'b0, 10'd1023);
    write_reg(RegSegCount, 64'd3);
    send_segment(1'b0, 10'd2);
    send_segment(1'b1, 10'd700);
    wait_drained();
  endtask

  task automatic test_matrix_corners();
    write_reg(RegColor, 64'd0);
    // w row all zero: saturated coordinates
    write_reg(RegRow3, 64'd0);
    send_segment(1'b0, 10'd1);
    send_segment(1'b1, 10'd2);
    write_reg(RegRow0, 64'h7FFF_7FFF_7FFF_7FFF);
    write_reg(RegRow1, 64'h8000_8000_8000_8000);
    write_reg(RegRow2, 64'hFFFF_0001_FFFF_0001);
    write_reg(RegRow3, 64'h0000_0000_0000_0001);
    send_segment(1'b0, 10'd5);
    send_segment(1'b1, 10'd1);
    write_reg(RegRow3, 64'h8000_8000_8000_8000);
    send_segment(1'b0, 10'd7);
    write_reg(RegColor, 64'hFF_FFFF);
    wait_drained();
  endtask

  task automatic test_random_stalls();
    for (int ph = 0; ph < 6; ph++) begin
      stall_mode = ph % 3;
      write_reg(RegCapped, 64'($urandom_range(0, 1)));
      write_reg(RegSegCount, ph == 5 ? 64'd1024 : 64'($urandom_range(1, 40)));
      write_reg(RegColor, 64'($urandom_range(0, 24'hFF_FFFF)));
      write_reg(RegRow0, rand_row());
      write_reg(RegRow1, rand_row());
      write_reg(RegRow2, rand_row());
      write_reg(RegRow3, (rand_row() & 64'hFFFF_FFFF_FFFF_0000) |
                         64'($urandom_range(1, 4) * 512));
      random_burst(8, ph == 5 ? 1023 : 60);
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    write_reg(RegCapped, 64'd1);
    write_reg(RegSegCount, 64'd16);
    write_reg(RegRow0, Row0Reset);
    write_reg(RegRow1, Row1Reset);
    write_reg(RegRow2, Row2Reset);
    write_reg(RegRow3, Row3Reset);
    stall_mode = 1;
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_burst(60, 31);
    join
    // sender waits for every expected vertex
    while (vertex_queue.size() != 0) @(posedge clk_i);
    random_burst(6, 1023);
    wait_drained();
  endtask

  initial begin
    sh_capped = 1'b0;
    sh_segs = SegReset;
    sh_color = ColorReset;
    sh_rows = '{Row0Reset, Row1Reset, Row2Reset, Row3Reset};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_identity();
    test_segment_extremes();
    test_matrix_corners();
    test_random_stalls();
    test_backpressure();
    $display("covered %0d segment items, %0d vertices, over identity, saturating,",
             n_items, n_vertices);
    $display("zero-w and random transforms with capping on and off and output stalls");
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
